[src/avexp_pkg.sv]
// ----------------------------------------------------------------------------
// avexp_pkg: shared definitions for the expression validator
// Verdict codes, divide tracking states, character constants and helpers.
// ----------------------------------------------------------------------------
package avexp_pkg;

    localparam int DEPTH_BITS = 16;

    typedef logic [DEPTH_BITS-1:0] t_depth;
    typedef logic [7:0]            t_char;

    typedef enum logic [2:0] {
        VERDICT_VALID   = 3'd0,
        VERDICT_EMPTY   = 3'd1,
        VERDICT_EXIT    = 3'd2,
        VERDICT_SYNTAX  = 3'd3,
        VERDICT_INVALID = 3'd4,
        VERDICT_DIVZERO = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        DIV_IDLE  = 2'd0,
        DIV_SLASH = 2'd1,
        DIV_ZERO  = 2'd2
    } t_div_track;

    localparam t_char CH_NUL    = 8'h00;
    localparam t_char CH_EXIT   = 8'h65;  // 'e'
    localparam t_char CH_ZERO   = 8'h30;  // '0'
    localparam t_char CH_NINE   = 8'h39;  // '9'
    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_MINUS  = 8'h2D;
    localparam t_char CH_STAR   = 8'h2A;
    localparam t_char CH_SLASH  = 8'h2F;
    localparam t_char CH_OPEN   = 8'h28;
    localparam t_char CH_CLOSE  = 8'h29;
    localparam t_char CH_SPACE  = 8'h20;

    function automatic logic is_op(input t_char c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[src/arith_expression_validator_core.sv]
// ----------------------------------------------------------------------------
// arith_expression_validator_core: streaming expression checker
// Takes one byte per request and returns a verdict on each terminator byte.
// ----------------------------------------------------------------------------
// A terminator's byte passes through the input register, then its verdict is registered in the output register.
// Throughput: one byte per cycle, but a terminator waits while an untaken verdict holds the output register.
// Bytes other than the terminator give no result and never wait on the output side.
// Reset (synchronous, active low) empties both registers and restores the start state.
module arith_expression_validator_core
    import avexp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_verdict
);

    logic       r_in_valid;
    t_char      r_char;
    logic       r_out_valid;
    t_verdict   r_verdict;

    t_depth     r_depth,    n_depth;
    logic       r_prev_op,  n_prev_op;
    t_div_track r_div,      n_div;
    logic       r_at_first, n_at_first;
    t_verdict   r_code,     n_code;
    t_verdict   n_verdict;

    logic       w_is_term;
    logic       w_advance;

    assign w_is_term  = (r_char == CH_NUL);
    // Only a terminator needs room in the output register.
    assign w_advance  = r_in_valid && (!w_is_term || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Next state of the scanner.
    always_comb begin
        logic v_done;
        v_done     = 1'b0;
        n_depth    = r_depth;
        n_prev_op  = r_prev_op;
        n_div      = r_div;
        n_at_first = r_at_first;
        n_code     = r_code;
        if (w_is_term) begin
            n_depth    = '0;
            n_prev_op  = 1'b0;
            n_div      = DIV_IDLE;
            n_at_first = 1'b1;
            n_code     = VERDICT_VALID;
        end else begin
            n_at_first = 1'b0;
            if (r_at_first && r_char == CH_EXIT) begin
                n_code = VERDICT_EXIT;
            end else if (r_code == VERDICT_VALID) begin
                case (r_div)
                    DIV_ZERO: begin
                        if (r_char == CH_SPACE || r_char == CH_CLOSE || is_op(r_char)) begin
                            n_code = VERDICT_DIVZERO;
                            v_done = 1'b1;
                        end else begin
                            n_div = DIV_IDLE;
                        end
                    end
                    DIV_SLASH: begin
                        if (r_char == CH_SPACE) begin
                            v_done = 1'b1;
                        end else begin
                            n_div = (r_char == CH_ZERO) ? DIV_ZERO : DIV_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!v_done && r_char != CH_SPACE) begin
                    if (is_digit(r_char) || is_op(r_char)
                        || r_char == CH_OPEN || r_char == CH_CLOSE) begin
                        if (r_char == CH_OPEN && (&r_depth)) begin
                            n_code = VERDICT_SYNTAX;
                        end else if (r_char == CH_CLOSE && r_depth == '0) begin
                            n_code = VERDICT_SYNTAX;
                        end else if (r_prev_op && is_op(r_char)) begin
                            n_code = VERDICT_SYNTAX;
                        end else begin
                            if (r_char == CH_OPEN) begin
                                n_depth = r_depth + t_depth'(1);
                            end else if (r_char == CH_CLOSE) begin
                                n_depth = r_depth - t_depth'(1);
                            end
                            n_prev_op = is_op(r_char);
                            if (r_char == CH_SLASH) begin
                                n_div = DIV_SLASH;
                            end
                        end
                    end else begin
                        n_code = VERDICT_INVALID;
                    end
                end
            end
        end
    end

    // Verdict for a terminator, in order of priority.
    always_comb begin
        if (r_at_first) begin
            n_verdict = VERDICT_EMPTY;
        end else if (r_code != VERDICT_VALID) begin
            n_verdict = r_code;
        end else if (r_div == DIV_ZERO) begin
            n_verdict = VERDICT_DIVZERO;
        end else if (r_depth != '0) begin
            n_verdict = VERDICT_SYNTAX;
        end else begin
            n_verdict = VERDICT_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_prev_op  <= 1'b0;
            r_div      <= DIV_IDLE;
            r_at_first <= 1'b1;
            r_code     <= VERDICT_VALID;
        end else if (w_advance) begin
            r_depth    <= n_depth;
            r_prev_op  <= n_prev_op;
            r_div      <= n_div;
            r_at_first <= n_at_first;
            r_code     <= n_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_term) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_is_term) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // A terminator always returns the scanner to its start state.
    a_term_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_is_term |=> r_at_first && r_depth == '0 && r_code == VERDICT_VALID)
        else $error("scanner not restarted after terminator");

    // An error can only be latched once the first byte has been seen.
    a_code_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_code != VERDICT_VALID |-> !r_at_first)
        else $error("error latched before first byte");

    // Divide tracking is idle at the start of an expression.
    a_div_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div != DIV_IDLE |-> !r_at_first)
        else $error("divide pending at start of expression");

    // A waiting verdict is never overwritten by the next terminator.
    a_verdict_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_verdict))
        else $error("pending verdict lost");

endmodule
